/* hdl/alf_pkg.sv */
package alf_pkg;

    // pixel and geometry widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;    // wide enough for any allowed region size
    localparam int POS_OUT_W  = 6;
    localparam int CFG_W      = 40;
    localparam int CFG_IDX_W  = 3;

    // line store and window shape
    localparam int STORE_ROWS = 6;
    localparam int WIN_ROWS   = 7;    // age 0 (current row) to age 6
    localparam int WIN_COLS   = 10;   // stored rows: columns m+3 down to m-6
    localparam int CUR_COLS   = 7;    // current row: columns m down to m-6
    localparam int CUR_OFS    = 3;    // current row slot offset inside a window row
    localparam int LOOKAHEAD  = 3;
    localparam int MARGIN     = 6;

    // window column of the filter centre
    localparam logic [3:0] JB_REG   = 4'd3;
    localparam logic [3:0] JB_FLUSH = 4'd6;

    // rounding
    localparam int ROUND_OFS  = 32;
    localparam int ROUND_SH   = 6;

    // queue depths
    localparam int JOB_DEPTH  = 4;
    localparam int RES_DEPTH  = 4;

    // filter taps: row offset and column offset, pairs share a coefficient
    localparam int NTAPS  = 17;
    localparam int NCOEF  = 9;
    localparam int TAP_DY [NTAPS] = '{-3, 3, -2, 2, -1, 1, -1, 1, -1, 1,
                                       0, 0, 0, 0, 0, 0, 0};
    localparam int TAP_DX [NTAPS] = '{0, 0, 0, 0, -1, 1, 0, 0, 1, -1,
                                       -3, 3, -2, 2, -1, 1, 0};

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [POS_W-1:0] t_pos;
    typedef t_pix [WIN_COLS-1:0] t_win_row;
    typedef t_win_row [WIN_ROWS-1:0] t_win;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERT   = 3'd0,
        REG_HORIZ  = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_ROWS   = 3'd3,
        REG_MAXPEL = 3'd4
    } t_reg_idx;

    // one classified input item with its pixel window, rows ordered by age
    typedef struct packed {
        t_win       win;
        t_pos       k;
        t_pos       reg_r;
        t_pos       reg_c;
        t_pos       fl_r0;
        t_pos       fl_c;
        logic       has_reg;
        logic [1:0] nflush;
    } t_job;

    typedef struct packed {
        t_pix                 pixel;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 last;
    } t_res;

endpackage

/* hdl/alf_ram.sv */
module alf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 70,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/alf_fifo.sv */
module alf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic [CNTW-1:0]  o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CNTW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_count = r_count;

endmodule

/* hdl/alf_front.sv */
module alf_front #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_ROWS  = 64,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_ROWS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  alf_pkg::t_pix i_pixel,
    input  logic [WW-1:0] i_width,
    input  logic [RW-1:0] i_rows,
    input  logic          i_restart,
    output logic          o_pending,
    output logic          o_push,
    output alf_pkg::t_job o_job
);

    localparam int ROW_LEN = MAX_WIDTH + alf_pkg::MARGIN;
    localparam int CW      = $clog2(ROW_LEN);
    localparam int SW      = $clog2(alf_pkg::STORE_ROWS);

    logic [RW-1:0] r_k, n_k;
    logic [CW-1:0] r_m, n_m;
    logic [SW-1:0] r_slot, n_slot;
    logic [CW:0]   m_inc;
    logic [CW:0]   row_end_pos;
    logic [CW:0]   look;
    logic [CW:0]   raddr;
    logic          last_row;
    logic          row_done;

    logic          r_f1_v;
    alf_pkg::t_pix r_f1_pix;
    logic [RW-1:0] r_f1_k;
    logic [CW-1:0] r_f1_m;
    logic [SW-1:0] r_f1_slot;
    logic          r_f1_last;

    alf_pkg::t_pix ram_q [alf_pkg::STORE_ROWS];
    alf_pkg::t_pix r_win [alf_pkg::STORE_ROWS][alf_pkg::WIN_COLS];
    alf_pkg::t_pix n_win [alf_pkg::STORE_ROWS][alf_pkg::WIN_COLS];
    alf_pkg::t_pix r_cur [alf_pkg::CUR_COLS];
    alf_pkg::t_pix n_cur [alf_pkg::CUR_COLS];

    logic          has_reg;
    logic          flush;
    logic [RW-1:0] rf0;
    logic [RW-1:0] nfl;

    // position bookkeeping
    assign m_inc       = (CW+1)'(r_m) + (CW+1)'(1);
    assign row_end_pos = (CW+1)'(i_width) + (CW+1)'(alf_pkg::MARGIN);
    assign row_done    = (m_inc >= row_end_pos);
    assign last_row    = ((RW+1)'(r_k) + (RW+1)'(1)) >= (RW+1)'(i_rows);

    // read three columns ahead, wrapping into the start of the next row
    assign look  = (CW+1)'(r_m) + (CW+1)'(alf_pkg::LOOKAHEAD);
    assign raddr = (look >= row_end_pos) ? look - row_end_pos : look;

    // counter next state
    always_comb begin
        n_k    = r_k;
        n_m    = r_m;
        n_slot = r_slot;
        if (i_restart) begin
            n_k    = '0;
            n_m    = '0;
            n_slot = '0;
        end else if (i_accept) begin
            if (row_done) begin
                n_m = '0;
                if (last_row) begin
                    n_k    = '0;
                    n_slot = '0;
                end else begin
                    n_k    = r_k + 1'b1;
                    n_slot = (r_slot == SW'(alf_pkg::STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                n_m = m_inc[CW-1:0];
            end
        end
    end

    // counters and the item waiting for its line store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_m    <= '0;
            r_slot <= '0;
            r_f1_v <= 1'b0;
        end else begin
            r_k    <= n_k;
            r_m    <= n_m;
            r_slot <= n_slot;
            r_f1_v <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_f1_pix  <= i_pixel;
            r_f1_k    <= r_k;
            r_f1_m    <= r_m;
            r_f1_slot <= r_slot;
            r_f1_last <= last_row;
        end
    end

    // one line store per stored row
    for (genvar s = 0; s < alf_pkg::STORE_ROWS; s++) begin : g_line
        alf_ram #(
            .WIDTH(alf_pkg::PIX_W),
            .DEPTH(ROW_LEN)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_accept && (r_slot == SW'(s))),
            .i_waddr(r_m),
            .i_wdata(i_pixel),
            .i_re   (i_accept),
            .i_raddr(raddr[CW-1:0]),
            .o_rdata(ram_q[s])
        );
    end

    // shifted window
    always_comb begin
        for (int s = 0; s < alf_pkg::STORE_ROWS; s++) begin
            n_win[s][0] = ram_q[s];
            for (int j = 1; j < alf_pkg::WIN_COLS; j++) begin
                n_win[s][j] = r_win[s][j-1];
            end
        end
        n_cur[0] = r_f1_pix;
        for (int j = 1; j < alf_pkg::CUR_COLS; j++) begin
            n_cur[j] = r_cur[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_v) begin
            r_win <= n_win;
            r_cur <= n_cur;
        end
    end

    // classify the item
    assign has_reg = (r_f1_k >= RW'(3)) && (r_f1_m >= CW'(3)) &&
                     ((CW+1)'(r_f1_m) < (CW+1)'(i_width) + (CW+1)'(3));
    assign flush   = r_f1_last && (r_f1_m >= CW'(alf_pkg::MARGIN));
    assign rf0     = (i_rows >= RW'(3)) ? i_rows - RW'(3) : '0;
    assign nfl     = i_rows - rf0;

    // job with window rows ordered by age
    always_comb begin
        logic [SW-1:0] sel;
        sel = '0;
        for (int j = 0; j < alf_pkg::WIN_COLS; j++) begin
            o_job.win[0][j] = (j >= alf_pkg::CUR_OFS) ? n_cur[j - alf_pkg::CUR_OFS] : '0;
        end
        for (int a = 1; a < alf_pkg::WIN_ROWS; a++) begin
            if (r_f1_slot >= SW'(a)) begin
                sel = r_f1_slot - SW'(a);
            end else begin
                sel = r_f1_slot + SW'(alf_pkg::STORE_ROWS - a);
            end
            for (int j = 0; j < alf_pkg::WIN_COLS; j++) begin
                o_job.win[a][j] = n_win[sel][j];
            end
        end
        o_job.k       = alf_pkg::t_pos'(r_f1_k);
        o_job.reg_r   = alf_pkg::t_pos'(r_f1_k) - alf_pkg::t_pos'(3);
        o_job.reg_c   = alf_pkg::t_pos'(r_f1_m) - alf_pkg::t_pos'(3);
        o_job.fl_r0   = alf_pkg::t_pos'(rf0);
        o_job.fl_c    = alf_pkg::t_pos'(r_f1_m) - alf_pkg::t_pos'(alf_pkg::MARGIN);
        o_job.has_reg = has_reg;
        o_job.nflush  = flush ? nfl[1:0] : 2'd0;
    end

    assign o_push    = r_f1_v && (has_reg || flush);
    assign o_pending = r_f1_v;

endmodule

/* hdl/alf_back.sv */
module alf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  alf_pkg::t_job               i_job,
    output logic                        o_job_pop,
    input  logic [alf_pkg::CFG_W-1:0]   i_vert,
    input  logic [31:0]                 i_horiz,
    input  alf_pkg::t_pos               i_rows,
    input  alf_pkg::t_pix               i_max_pel,
    input  logic                        i_res_full,
    output logic                        o_res_push,
    output alf_pkg::t_res               o_res
);

    logic [1:0]    r_idx;
    logic          en;
    logic          issue;
    logic          is_reg;
    logic [1:0]    fl_i;
    logic [2:0]    nres;
    logic          last;
    alf_pkg::t_pos cur_r;
    alf_pkg::t_pos cur_c;
    logic [3:0]    jb;
    alf_pkg::t_pix tap [alf_pkg::NTAPS];

    logic          r_s1_v;
    alf_pkg::t_pix r_s1_tap [alf_pkg::NTAPS];
    alf_pkg::t_pos r_s1_r;
    alf_pkg::t_pos r_s1_c;
    logic          r_s1_last;

    logic signed [7:0]  coef [alf_pkg::NCOEF];
    logic signed [17:0] prod [alf_pkg::NCOEF];
    logic               r_s2_v;
    logic signed [17:0] r_s2_prod [alf_pkg::NCOEF];
    alf_pkg::t_pos      r_s2_r;
    alf_pkg::t_pos      r_s2_c;
    logic               r_s2_last;

    logic signed [21:0] sum;
    alf_pkg::t_pix      pix;
    logic               r_s3_v;
    alf_pkg::t_res      r_s3_res;

    // pipeline moves unless stage 3 holds a result and the result queue is full
    assign en    = !r_s3_v || !i_res_full;
    assign issue = en && i_job_valid;

    // walk the results of the head job
    assign nres   = {2'b0, i_job.has_reg} + {1'b0, i_job.nflush};
    assign is_reg = i_job.has_reg && (r_idx == 2'd0);
    assign fl_i   = r_idx - {1'b0, i_job.has_reg};
    assign cur_r  = is_reg ? i_job.reg_r : i_job.fl_r0 + alf_pkg::t_pos'(fl_i);
    assign cur_c  = is_reg ? i_job.reg_c : i_job.fl_c;
    assign jb     = is_reg ? alf_pkg::JB_REG : alf_pkg::JB_FLUSH;
    assign last   = ({1'b0, r_idx} + 3'd1) == nres;
    assign o_job_pop = issue && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= last ? 2'd0 : r_idx + 1'b1;
        end
    end

    // tap selection with vertical clamp
    always_comb begin
        logic signed [9:0] y;
        logic signed [9:0] top;
        logic signed [9:0] age;
        logic [3:0]        col;
        y   = '0;
        age = '0;
        col = '0;
        top = $signed({2'b0, i_rows}) - 10'sd1;
        for (int t = 0; t < alf_pkg::NTAPS; t++) begin
            y = $signed({2'b0, cur_r}) + 10'(alf_pkg::TAP_DY[t]);
            if (y < 10'sd0) begin
                y = 10'sd0;
            end else if (y > top) begin
                y = top;
            end
            age    = $signed({2'b0, i_job.k}) - y;
            col    = jb - 4'(alf_pkg::TAP_DX[t]);
            tap[t] = i_job.win[age[2:0]][col];
        end
    end

    // stage 1: taps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_tap  <= tap;
            r_s1_r    <= cur_r;
            r_s1_c    <= cur_c;
            r_s1_last <= last;
        end
    end

    // coefficients
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            coef[i] = $signed(i_vert[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            coef[5+i] = $signed(i_horiz[8*i +: 8]);
        end
    end

    // pair sums, and the centre tap alone, times coefficients, operands widened before the multiply
    always_comb begin
        logic [8:0] pair;
        pair = '0;
        for (int i = 0; i < alf_pkg::NCOEF - 1; i++) begin
            pair    = {1'b0, r_s1_tap[2*i]} + {1'b0, r_s1_tap[2*i+1]};
            prod[i] = 18'(coef[i]) * 18'($signed({1'b0, pair}));
        end
        prod[alf_pkg::NCOEF-1] = 18'(coef[alf_pkg::NCOEF-1]) *
                                 18'($signed({2'b0, r_s1_tap[alf_pkg::NTAPS-1]}));
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_prod <= prod;
            r_s2_r    <= r_s1_r;
            r_s2_c    <= r_s1_c;
            r_s2_last <= r_s1_last;
        end
    end

    // sum, round and clip
    always_comb begin
        sum = 22'sd0 + 22'(alf_pkg::ROUND_OFS);
        for (int i = 0; i < alf_pkg::NCOEF; i++) begin
            sum = sum + 22'(r_s2_prod[i]);
        end
        if (sum < 22'sd0) begin
            pix = '0;
        end else if (sum[21:alf_pkg::ROUND_SH] > 16'(i_max_pel)) begin
            pix = i_max_pel;
        end else begin
            pix = sum[alf_pkg::ROUND_SH +: alf_pkg::PIX_W];
        end
    end

    // stage 3: finished result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_res.pixel <= pix;
            r_s3_res.row   <= r_s2_r[alf_pkg::POS_OUT_W-1:0];
            r_s3_res.col   <= r_s2_c[alf_pkg::POS_OUT_W-1:0];
            r_s3_res.last  <= r_s2_last;
        end
    end

    assign o_res_push = r_s3_v && !i_res_full;
    assign o_res      = r_s3_res;

endmodule

/* hdl/adaptive_loop_filter_7x7_cross.sv */
// 7x7 cross loop filter over one region, streamed one pixel per item.
// Input channel: push / full, with i_pixel_in carrying pixels in raster
// order, each row being region_width plus six margin pixels. Result
// channel: empty / pop; the oldest result sits on o_filtered_pixel,
// o_out_row, o_out_col and o_last_of_run while empty is low.
// Configuration: i_cfg_we, i_cfg_index and i_cfg_data write one register
// per cycle; writing width or rows restarts the raster position.
// Throughput: one item per cycle while a row gives at most one result and
// the receiver keeps popping. The filter pipeline delivers one result per
// cycle unless the result queue is full, so during the last row, where an
// item can give up to four results, the job queue can fill and raise full.
// On its way to the result queue a result passes the line store read,
// window shift, tap select, multiply, and sum and clip.
// Reset clears positions, queues and registers to their defaults; the line
// stores are not cleared, as only rows of the current region are read.
// When the receiver stalls, the result queue and the job queue fill and
// full rises; no item or result is dropped.
module adaptive_loop_filter_7x7_cross #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_ROWS  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_pixel_in,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_filtered_pixel,
    output logic [5:0]                      o_out_row,
    output logic [5:0]                      o_out_col,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_we,
    input  logic [alf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [alf_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int JCW  = $clog2(alf_pkg::JOB_DEPTH + 1);
    localparam int JW   = $bits(alf_pkg::t_job);
    localparam int RESW = $bits(alf_pkg::t_res);

    logic [alf_pkg::CFG_W-1:0] r_vert;
    logic [31:0]               r_horiz;
    logic [WW-1:0]             r_width;
    logic [RW-1:0]             r_rows;
    alf_pkg::t_pix             r_max_pel;

    logic [7:0]    cfg_low;
    logic [WW-1:0] sat_w;
    logic [RW-1:0] sat_r;
    logic          restart;
    logic          accept;
    logic          pending;
    logic          job_push;
    alf_pkg::t_job job_in;
    alf_pkg::t_job job_out;
    logic [JW-1:0] job_bits;
    logic          job_empty;
    logic          job_pop;
    logic [JCW-1:0] job_cnt;
    logic          res_push;
    logic          res_full;
    alf_pkg::t_res res_in;
    alf_pkg::t_res res_out;
    logic [RESW-1:0] res_bits;

    // saturated geometry values
    assign cfg_low = {1'b0, i_cfg_data[6:0]};
    assign sat_w   = (cfg_low == 8'd0) ? WW'(1) :
                     (cfg_low > 8'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_low);
    assign sat_r   = (cfg_low == 8'd0) ? RW'(1) :
                     (cfg_low > 8'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_low);

    assign restart = i_cfg_we &&
                     ((i_cfg_index == alf_pkg::REG_WIDTH) || (i_cfg_index == alf_pkg::REG_ROWS));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert    <= '0;
            r_horiz   <= '0;
            r_width   <= WW'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
            r_rows    <= RW'((MAX_ROWS < 64) ? MAX_ROWS : 64);
            r_max_pel <= 8'd255;
        end else if (i_cfg_we) begin
            case (alf_pkg::t_reg_idx'(i_cfg_index))
                alf_pkg::REG_VERT:   r_vert    <= i_cfg_data;
                alf_pkg::REG_HORIZ:  r_horiz   <= i_cfg_data[31:0];
                alf_pkg::REG_WIDTH:  r_width   <= sat_w;
                alf_pkg::REG_ROWS:   r_rows    <= sat_r;
                alf_pkg::REG_MAXPEL: r_max_pel <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input side: room for every item in flight toward the job queue
    assign full   = ((JCW+1)'(job_cnt) + (JCW+1)'(pending)) >= (JCW+1)'(alf_pkg::JOB_DEPTH);
    assign accept = push && !full;

    alf_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_pixel_in),
        .i_width  (r_width),
        .i_rows   (r_rows),
        .i_restart(restart),
        .o_pending(pending),
        .o_push   (job_push),
        .o_job    (job_in)
    );

    alf_fifo #(
        .WIDTH(JW),
        .DEPTH(alf_pkg::JOB_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .i_pop  (job_pop),
        .o_data (job_bits),
        .o_empty(job_empty),
        .o_full (),
        .o_count(job_cnt)
    );

    assign job_out = alf_pkg::t_job'(job_bits);

    alf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!job_empty),
        .i_job      (job_out),
        .o_job_pop  (job_pop),
        .i_vert     (r_vert),
        .i_horiz    (r_horiz),
        .i_rows     (alf_pkg::t_pos'(r_rows)),
        .i_max_pel  (r_max_pel),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    alf_fifo #(
        .WIDTH(RESW),
        .DEPTH(alf_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .i_pop  (pop),
        .o_data (res_bits),
        .o_empty(empty),
        .o_full (res_full),
        .o_count()
    );

    // result ports
    assign res_out          = alf_pkg::t_res'(res_bits);
    assign o_filtered_pixel = res_out.pixel;
    assign o_out_row        = res_out.row;
    assign o_out_col        = res_out.col;
    assign o_last_of_run    = res_out.last;

endmodule
